// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CACT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define CACT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/cact_pkg.sv =====
package cact_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int POOL_DEF    = 1024;
    localparam int INDEX_W     = 11;
    localparam int THR_W       = 12;
    localparam int TOTAL_W     = 12;

    localparam logic [31:0]        HASH_MUL  = 32'h1f1f1f1f;
    localparam logic [THR_W-1:0]   THR_RESET = 12'h800;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 12'hfff;

    typedef enum logic [1:0] {
        K_RECORD = 2'd0,
        K_READ   = 2'd1,
        K_CLEAR  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] hit_count;
        logic        new_arc;
        logic        dropped;
        logic        entry_valid;
        logic [31:0] entry_pc;
        logic [31:0] entry_ret;
    } t_result;

endpackage

// ===== sv/call_arc_count_table.sv =====
// Record: hash to a root, then fetch and check each chain slot, with a link step when
//   a pool entry is appended; a bucket count not a power of two adds reciprocal reduction
//   (quotient, remainder) in the hash unit. Read: fetch, check. Clear: a root slot pass.
// One item at a time; the table memory's single read and write port sets the walk pace.
// Reset (synchronous, active low) starts a clearing pass over the BUCKETS root slots,
//   one per cycle, with input stalled; threshold returns to 2048, counts to zero.
module call_arc_count_table import cact_pkg::*; #(
    parameter int BUCKETS      = BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_pc,
    input  logic [31:0]        i_ret_addr,
    input  logic [INDEX_W-1:0] i_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_hit_count,
    output logic               o_new_arc,
    output logic               o_dropped,
    output logic               o_full_res,
    output logic               o_entry_valid,
    output logic [31:0]        o_entry_pc,
    output logic [31:0]        o_entry_ret,
    output logic [TOTAL_W-1:0] o_arc_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [THR_W-1:0]   i_cfg_data
);

`include "assert_macros.svh"

    localparam int TABLE_SLOTS = BUCKETS + POOL_ENTRIES;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int POOL_W      = $clog2(POOL_ENTRIES + 1);
    localparam int BUCKET_W    = $clog2(BUCKETS);

    typedef struct packed {
        logic              valid;
        logic [31:0]       callee;
        logic [31:0]       caller;
        logic [31:0]       count;
        logic [SLOT_W-1:0] link;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_FETCH,
        S_CHECK,
        S_LINK,
        S_DONE
    } t_state;

    // pool slots are handed out in order, so their validity is a fill count;
    // roots carry a valid bit in the memory word
    function automatic logic slot_ok(input logic [SLOT_W-1:0] a, input logic root_v,
                                     input logic [POOL_W-1:0] used);
        if (32'(a) < 32'(BUCKETS)) begin
            return root_v;
        end
        return (32'(a) - 32'(BUCKETS)) < 32'(used);
    endfunction

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

    t_entry r_mem [TABLE_SLOTS];
    t_entry r_rd;

    t_state             r_state;
    t_kind              r_kind;
    logic [31:0]        r_pc;
    logic [31:0]        r_ret;
    logic               r_oob;
    logic               r_clr_item;
    logic [SLOT_W-1:0]  r_addr;
    logic [SLOT_W-1:0]  r_new;
    logic [POOL_W-1:0]  r_pool_used;
    logic [TOTAL_W-1:0] r_arcs;
    logic [THR_W-1:0]   r_thr;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;
    logic               r_full;
    logic [TOTAL_W-1:0] r_total;

    logic                hash_start;
    logic                hash_done;
    logic [BUCKET_W-1:0] hash_root;

    logic              accept;
    logic              cur_ok;
    logic              cur_match;
    logic              nxt_ok;
    logic              pool_full;
    logic [SLOT_W-1:0] new_slot;
    logic [31:0]       cnt_next;
    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    t_entry            fresh;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign hash_start = accept && (i_kind == K_RECORD);

    cact_hash #(.BUCKETS(BUCKETS)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_pc    (i_pc),
        .i_ret   (i_ret_addr),
        .o_done  (hash_done),
        .o_root  (hash_root)
    );

    always_comb begin
        cur_ok    = slot_ok(r_addr, r_rd.valid, r_pool_used);
        cur_match = (r_rd.callee == r_pc) && (r_rd.caller == r_ret);
        nxt_ok    = (r_rd.link != '0) && (32'(r_rd.link) < 32'(TABLE_SLOTS)) &&
                    slot_ok(r_rd.link, 1'b0, r_pool_used);
        pool_full = (32'(r_pool_used) >= 32'(POOL_ENTRIES));
        new_slot  = SLOT_W'(32'(BUCKETS) + 32'(r_pool_used));
        cnt_next  = (r_rd.count == '1) ? r_rd.count : r_rd.count + 32'd1;
        out_free  = !r_out_valid || !i_out_stall;
        out_load  = (r_state == S_DONE) && out_free;

        fresh        = '0;
        fresh.valid  = 1'b1;
        fresh.callee = r_pc;
        fresh.caller = r_ret;
        fresh.count  = 32'd1;

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = fresh;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_CHECK: begin
                if (r_kind == K_RECORD) begin
                    priority if (!cur_ok) begin
                        mem_we = 1'b1;
                    end else if (cur_match) begin
                        mem_we          = 1'b1;
                        mem_wdata       = r_rd;
                        mem_wdata.count = cnt_next;
                    end else if (!nxt_ok && !pool_full) begin
                        mem_we    = 1'b1;
                        mem_waddr = new_slot;
                    end else begin
                        mem_we = 1'b0;
                    end
                end
            end
            S_LINK: begin
                mem_we         = 1'b1;
                mem_wdata      = r_rd;
                mem_wdata.link = r_new;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_clr_item  <= 1'b0;
            r_pool_used <= '0;
            r_arcs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + SLOT_W'(1);
                    if (r_addr == SLOT_W'(BUCKETS - 1)) begin
                        r_state <= r_clr_item ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= t_kind'(i_kind);
                        r_pc   <= i_pc;
                        r_ret  <= i_ret_addr;
                        r_res  <= '0;
                        r_oob  <= ({{(32 - INDEX_W){1'b0}}, i_index} >= 32'(TABLE_SLOTS));
                        unique case (t_kind'(i_kind))
                            K_RECORD: r_state <= S_HASH;
                            K_READ: begin
                                r_addr  <= SLOT_W'(i_index);
                                r_state <= S_FETCH;
                            end
                            K_CLEAR: begin
                                r_pool_used <= '0;
                                r_arcs      <= '0;
                                r_addr      <= '0;
                                r_clr_item  <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            K_NOP: r_state <= S_DONE;
                        endcase
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_addr  <= SLOT_W'(hash_root);
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_kind == K_READ) begin
                        if (!r_oob && cur_ok) begin
                            r_res.entry_valid <= 1'b1;
                            r_res.hit_count   <= r_rd.count;
                            r_res.entry_pc    <= r_rd.callee;
                            r_res.entry_ret   <= r_rd.caller;
                        end
                        r_state <= S_DONE;
                    end else begin
                        priority if (!cur_ok) begin
                            r_arcs          <= bump(r_arcs);
                            r_res.hit_count <= 32'd1;
                            r_res.new_arc   <= 1'b1;
                            r_state         <= S_DONE;
                        end else if (cur_match) begin
                            r_res.hit_count <= cnt_next;
                            r_state         <= S_DONE;
                        end else if (nxt_ok) begin
                            r_addr  <= r_rd.link;
                            r_state <= S_FETCH;
                        end else if (pool_full) begin
                            r_res.dropped <= 1'b1;
                            r_state       <= S_DONE;
                        end else begin
                            r_new           <= new_slot;
                            r_pool_used     <= r_pool_used + POOL_W'(1);
                            r_arcs          <= bump(r_arcs);
                            r_res.hit_count <= 32'd1;
                            r_res.new_arc   <= 1'b1;
                            r_state         <= S_LINK;
                        end
                    end
                end
                S_LINK: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_full      <= (r_arcs >= r_thr);
                        r_total     <= r_arcs;
                        r_out_valid <= 1'b1;
                        r_clr_item  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_hit_count   = r_out.hit_count;
    assign o_new_arc     = r_out.new_arc;
    assign o_dropped     = r_out.dropped;
    assign o_entry_valid = r_out.entry_valid;
    assign o_entry_pc    = r_out.entry_pc;
    assign o_entry_ret   = r_out.entry_ret;
    assign o_full_res    = r_full;
    assign o_arc_total   = r_total;

    `CACT_ASSERT(a_pool_bound, i_clk, i_rst_n, r_pool_used <= POOL_W'(POOL_ENTRIES), "pool count beyond pool size")
    `CACT_ASSERT(a_new_or_drop, i_clk, i_rst_n, o_out_valid |-> !(o_new_arc && o_dropped), "item both new and dropped")
    `CACT_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "second item taken while busy")
    `CACT_ASSERT_ALWAYS(a_hash_wait, i_clk, hash_done |-> (r_state == S_HASH), "hash finished with no record waiting")

endmodule

// ===== sv/cact_hash.sv =====
module cact_hash import cact_pkg::*; #(
    parameter int BUCKETS = BUCKETS_DEF,
    localparam int BUCKET_W = $clog2(BUCKETS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_pc,
    input  logic [31:0]         i_ret,
    output logic                o_done,
    output logic [BUCKET_W-1:0] o_root
);

    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    // q = (x * MAGIC) >> (32 + BUCKET_W) is the exact quotient for any 32-bit x
    localparam logic [63:0] MAGIC_FULL =
        ((64'd1 << (32 + BUCKET_W)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [32:0] MAGIC   = MAGIC_FULL[32:0];
    localparam logic [31:0] DIVISOR = 32'(BUCKETS);

    typedef enum logic [1:0] {
        H_IDLE,
        H_QUOT,
        H_REM,
        H_DONE
    } t_phase;

    t_phase      r_phase;
    logic [31:0] r_word;
    logic [31:0] r_quot;

    logic [64:0] prod;

    always_comb begin
        prod = {33'd0, r_word} * {32'd0, MAGIC};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= H_IDLE;
        end else begin
            unique case (r_phase)
                H_IDLE: begin
                    if (i_start) begin
                        r_word  <= (i_pc * HASH_MUL) ^ i_ret;
                        r_phase <= IS_POW2 ? H_DONE : H_QUOT;
                    end
                end
                H_QUOT: begin
                    r_quot  <= 32'(prod >> (32 + BUCKET_W));
                    r_phase <= H_REM;
                end
                H_REM: begin
                    r_word  <= r_word - r_quot * DIVISOR;
                    r_phase <= H_DONE;
                end
                H_DONE: begin
                    r_phase <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_phase == H_DONE);
    assign o_root = r_word[BUCKET_W-1:0];

endmodule
